### hdl/first_fit_block_allocator_top_defines.svh
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ffba_pkg.sv
// Types, constants and control structs of the first-fit block allocator.
package ffba_pkg;

    localparam int BLOCKS    = 32;
    localparam int IDX_W     = $clog2(BLOCKS);
    localparam int PTR_W     = IDX_W + 1;
    localparam int SIZE_RAW  = $clog2((BLOCKS - 1) * 8 + 1);
    localparam int SIZE_W    = (SIZE_RAW < 8) ? 8 : SIZE_RAW;
    localparam int HDR_W     = SIZE_W + 1;
    localparam int REQ_W     = 8;
    localparam int PIDX_W    = 5;
    localparam int STAT_W    = 3;
    localparam int NEED_W    = REQ_W - 2;
    localparam int BSZ_W     = SIZE_W - 2;
    localparam int ADV_W     = ((PTR_W > BSZ_W) ? PTR_W : BSZ_W) + 1;
    localparam int NXT_W     = ((PTR_W > NEED_W) ? PTR_W : NEED_W) + 1;
    localparam int CMP_W     = (SIZE_W > NEED_W + 4) ? SIZE_W : NEED_W + 4;
    localparam int MATCH_W   = (PTR_W > PIDX_W) ? PTR_W : PIDX_W;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic [SIZE_W-1:0] INIT0_SIZE = SIZE_W'((BLOCKS - 1) * 8);

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NOTALLOC = 3'd4
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_EVAL,
        S_EVAL_REM,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    rd_sel_nxt;
        logic    rd_sel_adv;
        logic    wr_take;
        logic    wr_free;
        logic    wr_rem;
        logic    ptr_adv;
        logic    out_load;
        status_t status;
    } ffba_cmd_t;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic fit;
        logic rem_ok;
        logic match;
        logic hdr_taken;
        logic slot_empty;
        logic adv_end;
        logic out_free;
    } ffba_stat_t;

endpackage

### hdl/ffba_ram.sv
// Generic simple dual-port RAM with registered read.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/ffba_ctrl.sv
// Request sequencer: walks the header list and steers the datapath.
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ffba_stat_t stat,
    output ffba_cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!stat.is_free && stat.req_zero)
                begin
                    status_next = ST_ZERO;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!stat.is_free && stat.fit)
                begin
                    status_next = ST_OK;
                    state_next  = stat.rem_ok ? S_EVAL_REM : S_FINISH;
                end
                else if (stat.is_free && stat.match)
                begin
                    status_next = stat.hdr_taken ? ST_OK : ST_NOTALLOC;
                    state_next  = S_FINISH;
                end
                else if (stat.adv_end)
                begin
                    status_next = stat.is_free ? ST_NOTFOUND : ST_NOFIT;
                    state_next  = S_FINISH;
                end
            end
            S_EVAL_REM:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        cmd.status = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_START:
            begin
                cmd.rd_en = !(!stat.is_free && stat.req_zero);
            end
            S_EVAL:
            begin
                if (!stat.is_free && stat.fit)
                begin
                    cmd.wr_take = 1'b1;
                    // fetch the slot after the split point for a remainder header
                    cmd.rd_en      = stat.rem_ok;
                    cmd.rd_sel_nxt = 1'b1;
                end
                else if (stat.is_free && stat.match)
                begin
                    cmd.wr_free = stat.hdr_taken;
                end
                else
                begin
                    cmd.ptr_adv    = 1'b1;
                    cmd.rd_en      = !stat.adv_end;
                    cmd.rd_sel_adv = 1'b1;
                end
            end
            S_EVAL_REM:
            begin
                cmd.wr_rem = stat.slot_empty;
            end
            S_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/ffba_dp.sv
// Header store, walk pointer, header arithmetic and result register.
module ffba_dp
    import ffba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  ffba_cmd_t             cmd,
    output ffba_stat_t            stat
);

    cmd_t                cmd_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [PIDX_W-1:0]   target_reg;
    logic [NEED_W-1:0]   need_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic [SIZE_W-1:0]   csz_reg;

    logic [BLOCKS-1:0]   valid_reg;
    logic                rd_valid_reg;
    logic                rd_zero_reg;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [PIDX_W-1:0]   out_index_reg;

    logic [REQ_W-1:0]    in_req;
    logic [REQ_W:0]      in_req_p7;
    logic [HDR_W-1:0]    ram_q;
    logic [HDR_W-1:0]    hdr;
    logic                taken;
    logic [SIZE_W-1:0]   csz;
    logic [SIZE_W:0]     csz_p7;
    logic [BSZ_W-1:0]    bcsz;
    logic [ADV_W-1:0]    adv;
    logic [NXT_W-1:0]    nxt;
    logic [NEED_W:0]     need_p1;
    logic [NEED_W+3:0]   need_bytes;
    logic [CMP_W-1:0]    rem_full;
    logic [SIZE_W:0]     freed_full;
    logic [PTR_W-1:0]    ptr_p1;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [HDR_W-1:0]    wr_data;
    logic                wr_en;

    assign in_req    = s_tdata[REQ_W-1:0];
    assign in_req_p7 = (REQ_W+1)'(in_req) + (REQ_W+1)'(7);

    // an entry never written reads as its reset header
    assign hdr   = rd_valid_reg ? ram_q
                 : (rd_zero_reg ? {1'b0, INIT0_SIZE} : '0);
    assign taken = hdr[HDR_W-1];
    assign csz   = hdr[SIZE_W-1:0];

    assign csz_p7     = (SIZE_W+1)'(csz) + (SIZE_W+1)'(7);
    assign bcsz       = csz_p7[SIZE_W:3];
    assign adv        = ADV_W'(ptr_reg) + ADV_W'(bcsz) + ADV_W'(1);
    assign nxt        = NXT_W'(ptr_reg) + NXT_W'(need_reg) + NXT_W'(1);
    assign need_p1    = (NEED_W+1)'(need_reg) + (NEED_W+1)'(1);
    assign need_bytes = {need_p1, 3'b000};
    assign rem_full   = CMP_W'(csz_reg) - CMP_W'(need_bytes);
    assign freed_full = {bcsz, 3'b000};
    assign ptr_p1     = ptr_reg + PTR_W'(1);

    assign stat.is_free    = (cmd_reg == CMD_FREE);
    assign stat.req_zero   = (req_reg == '0);
    assign stat.fit        = !taken && (csz >= SIZE_W'(req_reg));
    assign stat.rem_ok     = (nxt < NXT_W'(BLOCKS)) && (CMP_W'(csz) >= CMP_W'(need_bytes));
    assign stat.match      = (MATCH_W'(ptr_p1) == MATCH_W'(target_reg));
    assign stat.hdr_taken  = taken;
    assign stat.slot_empty = !taken && (csz == '0);
    assign stat.adv_end    = (adv >= ADV_W'(BLOCKS));
    assign stat.out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        priority if (cmd.rd_sel_nxt)
        begin
            rd_addr = nxt[IDX_W-1:0];
        end
        else if (cmd.rd_sel_adv)
        begin
            rd_addr = adv[IDX_W-1:0];
        end
        else
        begin
            rd_addr = ptr_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        wr_en   = cmd.wr_take || cmd.wr_free || cmd.wr_rem;
        wr_addr = ptr_reg[IDX_W-1:0];
        wr_data = {1'b1, SIZE_W'(req_reg)};
        priority if (cmd.wr_rem)
        begin
            wr_addr = nxt[IDX_W-1:0];
            wr_data = {1'b0, rem_full[SIZE_W-1:0]};
        end
        else if (cmd.wr_free)
        begin
            wr_data = {1'b0, freed_full[SIZE_W-1:0]};
        end
        else
        begin
            wr_data = {1'b1, SIZE_W'(req_reg)};
        end
    end

    ffba_ram #(
        .WIDTH (HDR_W),
        .DEPTH (BLOCKS)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_zero_reg  <= 1'b0;
            cmd_reg      <= CMD_ALLOC;
            ptr_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_zero_reg  <= (rd_addr == '0);
            end
            if (cmd.load)
            begin
                cmd_reg <= cmd_t'(s_tuser);
                ptr_reg <= '0;
            end
            else if (cmd.ptr_adv)
            begin
                ptr_reg <= adv[PTR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= in_req;
            target_reg <= s_tdata[REQ_W+PIDX_W-1:REQ_W];
            need_reg   <= in_req_p7[REQ_W:3];
        end
        if (cmd.wr_take)
        begin
            csz_reg <= csz;
        end
    end

    // result register: hold until taken, refill on finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.status;
            if ((cmd.status == ST_OK) && (cmd_reg == CMD_ALLOC))
            begin
                out_index_reg <= PIDX_W'(ptr_p1);
            end
            else
            begin
                out_index_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_status_reg};

endmodule

### hdl/first_fit_block_allocator_top.sv
// First-fit block allocator: top level joining sequencer and datapath.
//
// Allocates and frees chunks in a store of BLOCKS 8-byte blocks kept as an
// implicit header list, first fit from block 0. One request is taken at a
// time: from one acceptance to the next a request passes a start step, one
// step per header visited, one more when an allocate checks the slot for a
// split-off remainder, and a finish step that loads the result, which turns
// valid in the same cycle that the next request can be taken. A walk visits
// at most BLOCKS headers and a split never follows a full walk. The pace is
// set by the header RAM, which returns one header per cycle to the walk
// loop. The result sits in an output register, so the next request is taken
// while the previous result still waits for m_tready; that request holds in
// its last cycle until the register frees up. Headers never written read as
// their reset value through one valid flop per entry, so no clear pass runs
// after reset.
module first_fit_block_allocator_top
    import ffba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] request_bytes, [12:8] payload_index
    input  logic                 s_tuser,   // [0] command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [2:0] status, [7:3] result_index
);

    ffba_cmd_t  cmd;
    ffba_stat_t stat;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffba_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

### hdl/ffba_checker.sv
// Port-level checks of the allocator, bound to the top level.
`include "first_fit_block_allocator_top_defines.svh"

module ffba_checker
    import ffba_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `FFBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `FFBA_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "second request taken while busy")
    `FFBA_ASSERT_NOW(a_index_only_ok, m_tvalid && (m_tdata[7:3] != 5'd0), m_tdata[2:0] == ST_OK, "index granted on failure")

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);
